[src/fmacc_pkg.sv]
`default_nettype none
// ============================================================================
// fmacc_pkg
// Shared widths, register codes, item types and saturating arithmetic for the
// force and moment accumulator.
// ============================================================================
package fmacc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = 64;
    localparam int LEV_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * LEV_W;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int EXT_W      = ((SHIFT_W > SUM_W) ? SHIFT_W : SUM_W) + 1;

    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam int NUM_REGS   = 4;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_REF_X = 2'd1,
        REG_REF_Y = 2'd2,
        REG_REF_Z = 2'd3
    } t_reg_idx;

    localparam logic MODE_BODY  = 1'b0;
    localparam logic MODE_EMBED = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [DATA_WIDTH-1:0] force_x;
        logic signed [DATA_WIDTH-1:0] force_y;
        logic signed [DATA_WIDTH-1:0] force_z;
        logic                         last;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] total_force_x;
        logic signed [SUM_W-1:0] total_force_y;
        logic signed [SUM_W-1:0] total_force_z;
        logic signed [SUM_W-1:0] total_moment_x;
        logic signed [SUM_W-1:0] total_moment_y;
        logic signed [SUM_W-1:0] total_moment_z;
    } t_out_item;

    // Classified work item: lever arm and effective force, ready to multiply
    typedef struct packed {
        logic signed [LEV_W-1:0] lev_x;
        logic signed [LEV_W-1:0] lev_y;
        logic signed [LEV_W-1:0] lev_z;
        logic signed [LEV_W-1:0] frc_x;
        logic signed [LEV_W-1:0] frc_y;
        logic signed [LEV_W-1:0] frc_z;
        logic                    last;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        case (s[SUM_W:SUM_W-1])
            2'b01:   return SUM_MAX;
            2'b10:   return SUM_MIN;
            default: return s[SUM_W-1:0];
        endcase
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sub(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} - {b[SUM_W-1], b};
        case (s[SUM_W:SUM_W-1])
            2'b01:   return SUM_MAX;
            2'b10:   return SUM_MIN;
            default: return s[SUM_W-1:0];
        endcase
    endfunction

    // Drop the fraction bits (floor) and clamp to the sum width
    function automatic logic signed [SUM_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SHIFT_W-1:0]   sh;
        logic signed [EXT_W-1:0]     ext;
        logic [EXT_W-SUM_W:0]        top;
        sh  = $signed(SHIFT_W'(p >>> FRAC_BITS));
        ext = EXT_W'(sh);
        top = ext[EXT_W-1:SUM_W-1];
        if ((&top) || !(|top)) begin
            return ext[SUM_W-1:0];
        end
        return ext[EXT_W-1] ? SUM_MIN : SUM_MAX;
    endfunction

endpackage
`default_nettype wire

[src/fmacc_in_if.sv]
`default_nettype none
// ============================================================================
// fmacc_in_if
// Point item channel: valid/ready handshake with one position and force.
// ============================================================================
interface fmacc_in_if import fmacc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/fmacc_out_if.sv]
`default_nettype none
// ============================================================================
// fmacc_out_if
// Result channel: valid/ready handshake carrying the six totals.
// ============================================================================
interface fmacc_out_if import fmacc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/fmacc_front.sv]
`default_nettype none
// ============================================================================
// fmacc_front
// Holds the configuration, accepts point items and forms lever arm and
// effective force for the queue.
// ============================================================================
module fmacc_front import fmacc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fmacc_in_if.sink              i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_wdata,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_work                 o_work
);

    logic                         r_mode;
    logic signed [DATA_WIDTH-1:0] r_ref_x;
    logic signed [DATA_WIDTH-1:0] r_ref_y;
    logic signed [DATA_WIDTH-1:0] r_ref_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BODY;
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:  r_mode  <= i_cfg_wdata[0];
                REG_REF_X: r_ref_x <= i_cfg_wdata;
                REG_REF_Y: r_ref_y <= i_cfg_wdata;
                REG_REF_Z: r_ref_z <= i_cfg_wdata;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    logic signed [LEV_W-1:0] w_lev_x, w_lev_y, w_lev_z;
    logic signed [LEV_W-1:0] w_frc_x, w_frc_y, w_frc_z;

    always_comb begin
        w_lev_x = {i_in.data.pos_x[DATA_WIDTH-1], i_in.data.pos_x}
                - {r_ref_x[DATA_WIDTH-1], r_ref_x};
        w_lev_y = {i_in.data.pos_y[DATA_WIDTH-1], i_in.data.pos_y}
                - {r_ref_y[DATA_WIDTH-1], r_ref_y};
        w_lev_z = {i_in.data.pos_z[DATA_WIDTH-1], i_in.data.pos_z}
                - {r_ref_z[DATA_WIDTH-1], r_ref_z};
        w_frc_x = {i_in.data.force_x[DATA_WIDTH-1], i_in.data.force_x};
        w_frc_y = {i_in.data.force_y[DATA_WIDTH-1], i_in.data.force_y};
        w_frc_z = {i_in.data.force_z[DATA_WIDTH-1], i_in.data.force_z};
        if (r_mode == MODE_BODY) begin
            // reaction force: negate
            w_frc_x = -w_frc_x;
            w_frc_y = -w_frc_y;
            w_frc_z = -w_frc_z;
        end else begin
            // embedded: drop lever components with no matching force
            if (w_frc_x == '0) w_lev_x = '0;
            if (w_frc_y == '0) w_lev_y = '0;
            if (w_frc_z == '0) w_lev_z = '0;
        end
    end

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    assign o_work.lev_x = w_lev_x;
    assign o_work.lev_y = w_lev_y;
    assign o_work.lev_z = w_lev_z;
    assign o_work.frc_x = w_frc_x;
    assign o_work.frc_y = w_frc_y;
    assign o_work.frc_z = w_frc_z;
    assign o_work.last  = i_in.data.last;

endmodule
`default_nettype wire

[src/fmacc_queue.sv]
`default_nettype none
// ============================================================================
// fmacc_queue
// Short first-in first-out queue of work items between front and back.
// ============================================================================
module fmacc_queue import fmacc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_work   i_work,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output logic    o_head_vld,
    output t_work   o_head
);

    t_work             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW:0]     n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head_vld   = !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

[src/fmacc_back.sv]
`default_nettype none
// ============================================================================
// fmacc_back
// Multiply, scale and accumulate pipeline; emits the six totals on the last
// item of a set and clears the sums.
// ============================================================================
module fmacc_back import fmacc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_vld,
    input  t_work      i_head,
    output logic       o_pop,
    fmacc_out_if.source o_out
);

    logic w_adv;

    // stage 1: products
    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic signed [PROD_W-1:0] r_p_xa, r_p_xb, r_p_ya, r_p_yb, r_p_za, r_p_zb;
    logic signed [LEV_W-1:0]  r_s1_fx, r_s1_fy, r_s1_fz;

    // stage 2: moment terms and widened forces
    logic                     r_s2_vld;
    logic                     r_s2_last;
    logic signed [SUM_W-1:0]  r_s2_mx, r_s2_my, r_s2_mz;
    logic signed [SUM_W-1:0]  r_s2_fx, r_s2_fy, r_s2_fz;

    // accumulators and result register
    logic signed [SUM_W-1:0]  r_sum_fx, r_sum_fy, r_sum_fz;
    logic signed [SUM_W-1:0]  r_sum_mx, r_sum_my, r_sum_mz;
    logic signed [SUM_W-1:0]  n_sum_fx, n_sum_fy, n_sum_fz;
    logic signed [SUM_W-1:0]  n_sum_mx, n_sum_my, n_sum_mz;
    logic                     r_out_vld;
    t_out_item                r_out;

    // hold the pipe only when a finished set meets an occupied result register
    assign w_adv = !(r_s2_vld && r_s2_last && r_out_vld && !o_out.ready);
    assign o_pop = i_head_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_head_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_xa    <= i_head.lev_y * i_head.frc_z;
            r_p_xb    <= i_head.lev_z * i_head.frc_y;
            r_p_ya    <= i_head.lev_z * i_head.frc_x;
            r_p_yb    <= i_head.lev_x * i_head.frc_z;
            r_p_za    <= i_head.lev_x * i_head.frc_y;
            r_p_zb    <= i_head.lev_y * i_head.frc_x;
            r_s1_fx   <= i_head.frc_x;
            r_s1_fy   <= i_head.frc_y;
            r_s1_fz   <= i_head.frc_z;
            r_s1_last <= i_head.last;

            r_s2_mx   <= sat_sub(scale_sat(r_p_xa), scale_sat(r_p_xb));
            r_s2_my   <= sat_sub(scale_sat(r_p_ya), scale_sat(r_p_yb));
            r_s2_mz   <= sat_sub(scale_sat(r_p_za), scale_sat(r_p_zb));
            r_s2_fx   <= SUM_W'(r_s1_fx);
            r_s2_fy   <= SUM_W'(r_s1_fy);
            r_s2_fz   <= SUM_W'(r_s1_fz);
            r_s2_last <= r_s1_last;
        end
    end

    always_comb begin
        n_sum_fx = sat_add(r_sum_fx, r_s2_fx);
        n_sum_fy = sat_add(r_sum_fy, r_s2_fy);
        n_sum_fz = sat_add(r_sum_fz, r_s2_fz);
        n_sum_mx = sat_add(r_sum_mx, r_s2_mx);
        n_sum_my = sat_add(r_sum_my, r_s2_my);
        n_sum_mz = sat_add(r_sum_mz, r_s2_mz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_fx <= '0;
            r_sum_fy <= '0;
            r_sum_fz <= '0;
            r_sum_mx <= '0;
            r_sum_my <= '0;
            r_sum_mz <= '0;
        end else if (w_adv && r_s2_vld) begin
            if (r_s2_last) begin
                r_sum_fx <= '0;
                r_sum_fy <= '0;
                r_sum_fz <= '0;
                r_sum_mx <= '0;
                r_sum_my <= '0;
                r_sum_mz <= '0;
            end else begin
                r_sum_fx <= n_sum_fx;
                r_sum_fy <= n_sum_fy;
                r_sum_fz <= n_sum_fz;
                r_sum_mx <= n_sum_mx;
                r_sum_my <= n_sum_my;
                r_sum_mz <= n_sum_mz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_s2_vld && r_s2_last) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_vld && r_s2_last) begin
            r_out.total_force_x  <= n_sum_fx;
            r_out.total_force_y  <= n_sum_fy;
            r_out.total_force_z  <= n_sum_fz;
            r_out.total_moment_x <= n_sum_mx;
            r_out.total_moment_y <= n_sum_my;
            r_out.total_moment_z <= n_sum_mz;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

[src/force_and_moment_accumulator.sv]
`default_nettype none
// ============================================================================
// force_and_moment_accumulator
// Resultant force and moment about a reference point over a set of points.
// ============================================================================
// Usage:
//   i_in  carries one point per transaction: position, force and a last flag.
//   o_out carries one transaction per set: three force totals and three
//         moment totals about the reference point, signed Q48.16, 64 bits,
//         saturating.
//   i_cfg_we/i_cfg_idx/i_cfg_wdata write mode (index 0) and the reference
//   point x/y/z (indexes 1..3); write them only while the block is idle.
// Timing:
//   One point per cycle while the queue has room. After a set's last point is
//   taken it passes the queue read, the product stage and the scale stage,
//   then the accumulate step loads the result register.
//   The multipliers (one product stage) and the accumulator set the rate.
// Stalls:
//   A four-entry queue parts the intake from the arithmetic. While a result
//   waits on o_out the arithmetic keeps summing the next set; it holds only
//   when a further last point reaches the accumulator, and the intake keeps
//   taking points until the queue fills.
// Reset:
//   Synchronous, active low. Clears mode, reference point, all sums, the
//   queue and the result valid.
// ============================================================================
module force_and_moment_accumulator import fmacc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fmacc_in_if.sink              i_in,
    fmacc_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_wdata
);

    t_q_stat w_q_stat;
    logic    w_push;
    t_work   w_work;
    logic    w_head_vld;
    t_work   w_head;
    logic    w_pop;

    // intake: config, lever arm and effective force
    fmacc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_work      (w_work)
    );

    // decouple intake from arithmetic
    fmacc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_work     (w_work),
        .i_pop      (w_pop),
        .o_stat     (w_q_stat),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    // products, scaling, saturating sums and the result register
    fmacc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    // result valid drops with reset
    a_out_idle_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_out.valid
    ) else $error("result valid after reset");

    // never read an empty queue
    a_pop_not_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |-> !w_q_stat.empty
    ) else $error("queue read while empty");

    // an empty queue always lets the intake take a point
    a_ready_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_q_stat.empty |-> i_in.ready
    ) else $error("intake stalled with empty queue");

    // a push into a full queue cannot happen
    a_no_push_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_q_stat.full
    ) else $error("push into full queue");

endmodule
`default_nettype wire
